### rtl/gsbg_pkg.sv
package gsbg_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned DELAY_W  = 30;
	localparam int unsigned TTN_W    = 31;
	localparam int unsigned VOL_W    = 8;
	localparam int unsigned STEP_W   = 16;
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned FRAC_W   = 17;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [TTN_W-1:0]  IDLE_GAP   = 31'h4000_0000;
	localparam logic [FRAC_W-1:0] ONE_SAMPLE = 17'h1_0000;

	typedef enum logic {
		REG_VOLUME     = 1'b0,
		REG_PHASE_STEP = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LOAD_FIRST,
		ST_CLASSIFY,
		ST_LOOP,
		ST_LOAD_NEXT,
		ST_SCALE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic push;
		logic start_batch;
		logic take;
		logic load;
		logic whole;
		logic loop_init;
		logic loop_step;
		logic loop_exit;
		logic scale;
		logic zero_s;
		logic capture;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic vol_zero;
		logic in_batch;
		logic q_empty;
		logic ttn_ge_one;
		logic remain_ge_ttn;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/gsbg_if.sv
interface gsbg_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [gsbg_pkg::DELAY_W-1:0]   delay;
	logic                           gate_on;
	logic                           batch_end;

	modport source (output valid, output action, output delay, output gate_on,
		output batch_end, input ready);
	modport sink (input valid, input action, input delay, input gate_on,
		input batch_end, output ready);
endinterface

interface gsbg_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [gsbg_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### rtl/gsbg_ram.sv
module gsbg_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/gsbg_regs.sv
module gsbg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gsbg_pkg::APB_AW-1:0]   paddr,
	input  logic [gsbg_pkg::APB_DW-1:0]   pwdata,
	output logic [gsbg_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [gsbg_pkg::VOL_W-1:0]    volume,
	output logic [gsbg_pkg::STEP_W-1:0]   phase_step
);
	import gsbg_pkg::*;

	logic [VOL_W-1:0]  volume_q;
	logic [STEP_W-1:0] phase_step_q;
	reg_idx_t          idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q     <= '0;
			phase_step_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_VOLUME:     volume_q     <= pwdata[VOL_W-1:0];
				REG_PHASE_STEP: phase_step_q <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_VOLUME:     prdata = {{(APB_DW-VOL_W){1'b0}}, volume_q};
			REG_PHASE_STEP: prdata = {{(APB_DW-STEP_W){1'b0}}, phase_step_q};
			default:        prdata = '0;
		endcase
	end

	assign volume     = volume_q;
	assign phase_step = phase_step_q;
endmodule

### rtl/gsbg_ctrl.sv
module gsbg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_action,
	output logic                 in_ready,
	input  gsbg_pkg::dp_status_t sts,
	output gsbg_pkg::dp_cmd_t    cmd
);
	import gsbg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   acc_in;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_in && in_action) begin
					if (sts.vol_zero) begin
						state_d = ST_EMIT;
					end else if (!sts.in_batch) begin
						state_d = ST_START;
					end else begin
						state_d = ST_CLASSIFY;
					end
				end
			end
			ST_START:      state_d = sts.q_empty ? ST_CLASSIFY : ST_LOAD_FIRST;
			ST_LOAD_FIRST: state_d = ST_CLASSIFY;
			ST_CLASSIFY:   state_d = sts.ttn_ge_one ? ST_EMIT : ST_LOOP;
			ST_LOOP: begin
				if (sts.remain_ge_ttn) begin
					if (!sts.q_empty) begin
						state_d = ST_LOAD_NEXT;
					end
				end else begin
					state_d = ST_SCALE;
				end
			end
			ST_LOAD_NEXT:  state_d = ST_LOOP;
			ST_SCALE:      state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.push    = acc_in && !in_action;
				cmd.capture = acc_in && in_action;
				cmd.zero_s  = acc_in && in_action && sts.vol_zero;
			end
			ST_START: begin
				cmd.start_batch = 1'b1;
				cmd.take        = !sts.q_empty;
			end
			ST_LOAD_FIRST: cmd.load = 1'b1;
			ST_CLASSIFY: begin
				cmd.whole     = sts.ttn_ge_one;
				cmd.loop_init = !sts.ttn_ge_one;
			end
			ST_LOOP: begin
				cmd.loop_step = sts.remain_ge_ttn;
				cmd.take      = sts.remain_ge_ttn && !sts.q_empty;
				cmd.loop_exit = !sts.remain_ge_ttn;
			end
			ST_LOAD_NEXT:  cmd.load  = 1'b1;
			ST_SCALE:      cmd.scale = 1'b1;
			ST_EMIT:       cmd.emit  = sts.out_free;
			default: ;
		endcase
	end
endmodule

### rtl/gsbg_dp.sv
module gsbg_dp #(
	parameter int unsigned QUEUE_DEPTH = gsbg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gsbg_pkg::DELAY_W-1:0]  in_delay,
	input  logic                          in_gate_on,
	input  logic                          in_batch_end,
	input  logic [gsbg_pkg::VOL_W-1:0]    volume,
	input  logic [gsbg_pkg::STEP_W-1:0]   phase_step,
	input  gsbg_pkg::dp_cmd_t             cmd,
	output gsbg_pkg::dp_status_t          sts,
	gsbg_res_if.source                    res
);
	import gsbg_pkg::*;

	localparam int unsigned PW    = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned ENT_W = DELAY_W + 1;
	localparam int unsigned PROD_W = FRAC_W + VOL_W;

	logic [TTN_W-1:0]        ttn_q;
	logic                    pend_q;
	logic                    gate_q;
	logic [PHASE_W-1:0]      phase_q;
	logic                    in_batch_q;
	logic [PW-1:0]           rd_ptr_q;
	logic [PW-1:0]           wr_ptr_q;
	logic [FRAC_W-1:0]       remain_q;
	logic [FRAC_W-1:0]       acc_q;
	logic                    be_q;
	logic [SAMPLE_W-1:0]     smp_q;
	logic                    out_valid_q;
	logic [SAMPLE_W-1:0]     out_sample_q;

	logic                    q_empty;
	logic                    q_full;
	logic [ENT_W-1:0]        rdata;
	logic [TTN_W-1:0]        remain_ext;

	logic [PHASE_W-1:0]      p1, p2, p3, p4;
	logic [2:0]              n_high;
	logic signed [4:0]       sq_sum;
	logic signed [13:0]      sq_prod;
	logic [SAMPLE_W-1:0]     whole_s;
	logic [PROD_W-1:0]       frac_prod;
	logic [PROD_W-7:0]       frac_shr;
	logic [SAMPLE_W-1:0]     frac_s;

	assign q_empty    = (rd_ptr_q == wr_ptr_q);
	assign q_full     = (wr_ptr_q == PW'(QUEUE_DEPTH));
	assign remain_ext = {{(TTN_W-FRAC_W){1'b0}}, remain_q};

	gsbg_ram #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (cmd.push && !q_full),
		.waddr (wr_ptr_q[AW-1:0]),
		.wdata ({in_gate_on, in_delay}),
		.re    (cmd.take),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// four square decisions of one whole sample
	assign p1     = phase_q + phase_step;
	assign p2     = p1 + phase_step;
	assign p3     = p2 + phase_step;
	assign p4     = p3 + phase_step;
	assign n_high = 3'(phase_q[PHASE_W-1]) + 3'(p1[PHASE_W-1])
		+ 3'(p2[PHASE_W-1]) + 3'(p3[PHASE_W-1]);
	assign sq_sum  = $signed({1'b0, n_high, 1'b0}) - 5'sd4;
	assign sq_prod = sq_sum * $signed({1'b0, volume});
	assign whole_s = (sq_prod >= -14'sd128 && sq_prod <= 14'sd127) ?
		{sq_prod[7:0], 8'h00} : '0;

	assign frac_prod = acc_q * volume;
	assign frac_shr  = frac_prod[PROD_W-1:6];
	assign frac_s    = (|frac_shr[PROD_W-7:SAMPLE_W-1]) ? '0 : frac_shr[SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttn_q       <= '0;
			pend_q      <= 1'b0;
			gate_q      <= 1'b0;
			phase_q     <= '0;
			in_batch_q  <= 1'b0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push && !q_full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd.take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end

			if (cmd.start_batch) begin
				in_batch_q <= 1'b1;
				if (q_empty) begin
					ttn_q  <= IDLE_GAP;
					pend_q <= gate_q;
				end
			end

			if (cmd.load) begin
				ttn_q  <= {1'b0, rdata[DELAY_W-1:0]};
				pend_q <= rdata[DELAY_W];
			end

			if (cmd.whole) begin
				ttn_q <= ttn_q - {{(TTN_W-FRAC_W){1'b0}}, ONE_SAMPLE};
				if (gate_q) begin
					phase_q <= p4;
				end
			end

			if (cmd.loop_step) begin
				gate_q  <= pend_q;
				phase_q <= '0;
				if (q_empty) begin
					ttn_q <= IDLE_GAP;
				end
			end

			if (cmd.loop_exit) begin
				ttn_q <= ttn_q - remain_ext;
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit && be_q) begin
				gate_q     <= pend_q;
				rd_ptr_q   <= '0;
				wr_ptr_q   <= '0;
				in_batch_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			be_q <= in_batch_end && (volume != '0);
		end
		if (cmd.zero_s) begin
			smp_q <= '0;
		end
		if (cmd.whole) begin
			smp_q <= gate_q ? whole_s : '0;
		end
		if (cmd.loop_init) begin
			remain_q <= ONE_SAMPLE;
			acc_q    <= '0;
		end
		if (cmd.loop_step) begin
			remain_q <= remain_q - ttn_q[FRAC_W-1:0];
			if (gate_q) begin
				acc_q <= acc_q + ttn_q[FRAC_W-1:0];
			end
		end
		if (cmd.loop_exit && gate_q) begin
			acc_q <= acc_q + remain_q;
		end
		if (cmd.scale) begin
			smp_q <= frac_s;
		end
		if (cmd.emit) begin
			out_sample_q <= smp_q;
		end
	end

	assign res.valid  = out_valid_q;
	assign res.sample = out_sample_q;

	assign sts.vol_zero      = (volume == '0);
	assign sts.in_batch      = in_batch_q;
	assign sts.q_empty       = q_empty;
	assign sts.ttn_ge_one    = |ttn_q[TTN_W-1:FRAC_W-1];
	assign sts.remain_ge_ttn = (remain_ext >= ttn_q);
	assign sts.out_free      = !out_valid_q || res.ready;
endmodule

### rtl/gated_square_beep_generator.sv
// channel | dir | fields                                | handshake
// req     | in  | action, delay[29:0], gate_on, batch_end | valid/ready
// res     | out | sample[15:0] signed                    | valid/ready
// apb     | in  | volume @0x0, phase_step @0x4           | psel/penable, pready=1
//
// A gate event item is queued (dropped when the queue is full) and leaves
// the input ready. A whole sample passes IDLE, CLASSIFY and EMIT, plus START
// at batch start and LOAD_FIRST when a queued event is fetched then (the
// event queue RAM has a registered read). A sample holding boundaries adds
// LOOP and SCALE, with a LOOP step per boundary and LOAD_NEXT per fetch.
// Output register frees the input side; a stalled result holds the next one.
// Reset is asynchronous; control state clears to 0, sample data regs do not.
module gated_square_beep_generator #(
	parameter int unsigned QUEUE_DEPTH = gsbg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gsbg_req_if.sink                      req,
	gsbg_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gsbg_pkg::APB_AW-1:0]   paddr,
	input  logic [gsbg_pkg::APB_DW-1:0]   pwdata,
	output logic [gsbg_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import gsbg_pkg::*;

	logic [VOL_W-1:0]  volume;
	logic [STEP_W-1:0] phase_step;
	dp_cmd_t           cmd;
	dp_status_t        sts;
	logic              in_ready;

	gsbg_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.volume     (volume),
		.phase_step (phase_step)
	);

	gsbg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	assign req.ready = in_ready;

	gsbg_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_delay     (req.delay),
		.in_gate_on   (req.gate_on),
		.in_batch_end (req.batch_end),
		.volume       (volume),
		.phase_step   (phase_step),
		.cmd          (cmd),
		.sts          (sts),
		.res          (res)
	);
endmodule

### rtl/gsbg_checker.sv
module gsbg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           req_action,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [gsbg_pkg::SAMPLE_W-1:0]  res_sample
);
	logic [1:0] open_q;
	logic       req_smp;
	logic       res_acc;

	assign req_smp = req_valid && req_ready && req_action;
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 2'(req_smp) - 2'(res_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_sample))
		else $error("result dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> open_q != 2'd0)
		else $error("result without a sample request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 2'd2)
		else $error("more than two sample requests outstanding");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_smp |=> !req_ready)
		else $error("input ready straight after a sample request");
endmodule

bind gated_square_beep_generator gsbg_checker u_gsbg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_sample (res.sample)
);

### tb/sv/tb_gated_square_beep_generator.sv
module tb_gated_square_beep_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import gsbg_pkg::*;

	localparam int unsigned QD = QUEUE_DEPTH_DEF;
	localparam logic ACT_EVENT = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned LONG_RUN = 48;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 60;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	gsbg_req_if req_ch();
	gsbg_res_if res_ch();

	gated_square_beep_generator #(.QUEUE_DEPTH(QD)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor state
	logic [VOL_W-1:0] vol_cfg;
	logic [STEP_W-1:0] inc_cfg;
	logic [DELAY_W-1:0] ev_delay [QD];
	logic ev_on [QD];
	int unsigned ev_count;
	int unsigned ev_rd;
	logic [TTN_W-1:0] gap_left;
	logic pend_en;
	logic gate_st;
	logic [PHASE_W-1:0] phase_st;
	logic in_batch_st;

	logic signed [SAMPLE_W-1:0] samples_due [$];

	int unsigned errors;
	int unsigned items_sent;
	int unsigned samples_checked;
	int unsigned boundary_samples;
	int unsigned clipped_samples;
	int unsigned dropped_events;
	int unsigned src_rate;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void flag_error(string what, int want, int got);
		errors++;
		if (errors <= 10)
			$display("%s: expected %0d, got %0d at %0t", what, want, got, $time);
	endfunction

	function automatic void clear_model();
		vol_cfg = '0;
		inc_cfg = '0;
		ev_count = 0;
		ev_rd = 0;
		gap_left = '0;
		pend_en = 1'b0;
		gate_st = 1'b0;
		phase_st = '0;
		in_batch_st = 1'b0;
	endfunction

	function automatic bit pull_event();
		if (ev_count == 0 || ev_rd >= QD)
			return 1'b0;
		ev_count--;
		gap_left = TTN_W'(ev_delay[ev_rd]);
		pend_en = ev_on[ev_rd];
		ev_rd++;
		return 1'b1;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] fold_range(int v);
		if (v > 32767 || v < -32768) begin
			clipped_samples++;
			return '0;
		end
		return SAMPLE_W'(v);
	endfunction

	task automatic beep_predict(input logic act, input logic [DELAY_W-1:0] dly,
		input logic on, input logic last);
		int tally;
		int s;
		int unsigned remain;
		int unsigned acc;
		s = 0;
		if (act == ACT_EVENT) begin
			if (ev_rd + ev_count < QD) begin
				ev_delay[ev_rd + ev_count] = dly;
				ev_on[ev_rd + ev_count] = on;
				ev_count++;
			end else begin
				dropped_events++;
			end
			return;
		end
		if (vol_cfg == '0) begin
			samples_due.push_back('0);
			return;
		end
		if (!in_batch_st) begin
			in_batch_st = 1'b1;
			if (!pull_event()) begin
				gap_left = IDLE_GAP;
				pend_en = gate_st;
			end
		end
		if (gap_left >= ONE_SAMPLE) begin
			gap_left -= ONE_SAMPLE;
			if (gate_st) begin
				tally = 0;
				for (int k = 0; k < 4; k++) begin
					tally += phase_st[PHASE_W-1] ? 1 : -1;
					phase_st += inc_cfg;
				end
				s = tally * int'(vol_cfg) * 256;
			end
		end else begin
			boundary_samples++;
			remain = 32'h1_0000;
			acc = 0;
			while (remain >= gap_left) begin
				remain -= gap_left;
				if (gate_st)
					acc += gap_left;
				gate_st = pend_en;
				phase_st = '0;
				if (!pull_event())
					gap_left = IDLE_GAP;
			end
			gap_left -= remain;
			if (gate_st)
				acc += remain;
			s = int'((acc * vol_cfg) >> 6);
		end
		if (last) begin
			gate_st = pend_en;
			ev_count = 0;
			ev_rd = 0;
			in_batch_st = 1'b0;
		end
		samples_due.push_back(fold_range(s));
	endtask

	// caller sits just after a rising edge
	task automatic send_item(input logic act, input logic [DELAY_W-1:0] dly,
		input logic on, input logic last);
		int unsigned gap;
		gap = 0;
		if (!no_idle && src_rate != 0 && $urandom_range(1, src_rate) == 1)
			gap = $urandom_range(1, 18);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.delay <= dly;
		req_ch.gate_on <= on;
		req_ch.batch_end <= last;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		beep_predict(act, dly, on, last);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (samples_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] kept;
		kept = (idx == REG_VOLUME) ? (value & 32'hFF) : (value & 32'hFFFF);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_VOLUME)
			vol_cfg = kept[VOL_W-1:0];
		else
			inc_cfg = kept[STEP_W-1:0];
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== kept)
			flag_error("register read-back", int'(kept), int'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_tone(input logic [VOL_W-1:0] v, input logic [STEP_W-1:0] inc);
		drain();
		write_reg(REG_VOLUME, {24'($urandom()), v});
		write_reg(REG_PHASE_STEP, {16'($urandom()), inc});
	endtask

	function automatic logic [VOL_W-1:0] pick_volume();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd31;
			3: return 8'd32;
			4: return 8'd255;
			default: return VOL_W'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_inc();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return STEP_W'($urandom_range(1, 16'h0FFF));
			default: return STEP_W'($urandom());
		endcase
	endfunction

	function automatic logic [DELAY_W-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DELAY_W'(32'h1_0000 * $urandom_range(1, 3));
			2: return DELAY_W'($urandom());
			3: return '1;
			default: return DELAY_W'($urandom_range(0, 4 * 32'h1_0000));
		endcase
	endfunction

	task automatic random_batch();
		int unsigned n_ev;
		int unsigned n_smp;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 6))
				send_item(1'($urandom()), DELAY_W'($urandom()), 1'($urandom()),
					1'($urandom()));
			return;
		end
		n_ev = $urandom_range(0, 6);
		n_smp = $urandom_range(1, 8);
		repeat (n_ev)
			send_item(ACT_EVENT, pick_delay(), 1'($urandom()), 1'($urandom()));
		for (int i = 0; i < n_smp; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(ACT_EVENT, pick_delay(), 1'($urandom()), 1'b0);
			send_item(ACT_SAMPLE, DELAY_W'($urandom()), 1'($urandom()), i == n_smp - 1);
		end
	endtask

	task automatic test_directed_cases();
		// silent block: events still queue, batch end ignored
		set_tone(8'd0, 16'd0);
		send_item(ACT_EVENT, '1, 1'b1, 1'b0);
		send_item(ACT_SAMPLE, '1, 1'b1, 1'b1);
		set_tone(8'd255, 16'hFFFF);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b1);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		set_tone(8'd32, 16'h4000);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b1);
		set_tone(8'd1, 16'h0000);
		send_item(ACT_EVENT, '0, 1'b1, 1'b0);
		send_item(ACT_EVENT, 30'h8000, 1'b0, 1'b0);
		send_item(ACT_EVENT, 30'h4000, 1'b1, 1'b0);
		send_item(ACT_EVENT, 30'h1_0000, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '1, 1'b1, 1'b1);
	endtask

	task automatic test_queue_capacity();
		set_tone(8'd5, STEP_W'($urandom()));
		repeat (QD + 2)
			send_item(ACT_EVENT, 30'h2000, 1'($urandom()), 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		// read position plus count sits at the end: these fall off
		repeat (3)
			send_item(ACT_EVENT, 30'h1000, 1'b1, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b1);
		repeat (4)
			send_item(ACT_EVENT, 30'h6000, 1'($urandom()), 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		repeat (2)
			send_item(ACT_EVENT, 30'h3000, 1'($urandom()), 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b0);
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b1);
	endtask

	task automatic test_long_batch();
		set_tone(VOL_W'($urandom_range(1, 31)), STEP_W'($urandom_range(1, 16'hFFFF)));
		send_item(ACT_EVENT, '0, 1'b1, 1'b0);
		for (int n = 0; n < LONG_RUN; n++)
			send_item(ACT_SAMPLE, DELAY_W'($urandom()), 1'($urandom()), n == LONG_RUN - 1);
	endtask

	task automatic test_random_batches();
		int unsigned phase_end;
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				set_tone(8'd255, 16'hFFFF);
			else if (p == 1)
				set_tone(8'd1, 16'h0000);
			else
				set_tone(pick_volume(), pick_inc());
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 15) == 0)
					src_rate = 4 * $urandom_range(0, 3);
				random_batch();
				if ($urandom_range(0, 11) == 0)
					drain();
			end
		end
	endtask

	task automatic test_unpaced_tail();
		no_idle = 1'b1;
		set_tone(VOL_W'($urandom_range(1, 40)), pick_inc());
		repeat (8)
			random_batch();
		send_item(ACT_SAMPLE, '0, 1'b0, 1'b1);
	endtask

	// result side stalls
	initial begin
		int unsigned rate;
		rate = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				rate = 4 * $urandom_range(0, 3);
			if (!no_idle && rate != 0 && $urandom_range(1, rate) == 1) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (samples_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("sample %0d arrived with none due at %0t",
						res_ch.sample, $time);
			end else begin
				want = samples_due.pop_front();
				samples_checked++;
				if (res_ch.sample !== want)
					flag_error("sample", int'(want), int'(res_ch.sample));
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("[gated_square_beep_generator] ERROR");
		$finish;
	end

	initial begin
		errors = 0;
		items_sent = 0;
		samples_checked = 0;
		boundary_samples = 0;
		clipped_samples = 0;
		dropped_events = 0;
		src_rate = 8;
		no_idle = 1'b0;
		clear_model();
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_EVENT;
		req_ch.delay <= '0;
		req_ch.gate_on <= 1'b0;
		req_ch.batch_end <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_queue_capacity();
		test_long_batch();
		test_random_batches();
		test_unpaced_tail();

		drain();
		errors += samples_due.size();
		$display("covered %0d items, %0d samples checked, %0d across gate events, %0d out of range",
			items_sent, samples_checked, boundary_samples, clipped_samples);
		$display("%0d events dropped on a full queue; one batch ran %0d samples unbroken",
			dropped_events, LONG_RUN);
		if (errors == 0)
			$display("[gated_square_beep_generator] OK");
		else
			$display("[gated_square_beep_generator] ERROR");
		$finish;
	end
endmodule

### filelist.f
rtl/gsbg_pkg.sv
rtl/gsbg_if.sv
rtl/gsbg_ram.sv
rtl/gsbg_regs.sv
rtl/gsbg_ctrl.sv
rtl/gsbg_dp.sv
rtl/gated_square_beep_generator.sv
rtl/gsbg_checker.sv
tb/sv/tb_gated_square_beep_generator.sv
